// ===== src/c8_pkg.sv =====
// Shared types and constants for the CHIP-8 instruction core.
// Holds the action and status codes, the font table and the ALU result type.
// No dependencies.
package c8_pkg;

    localparam int MEMORY_BYTES   = 4096;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int SCREEN_WIDTH   = 64;
    localparam int SCREEN_HEIGHT  = 32;
    localparam int ADDR_W         = $clog2(MEMORY_BYTES);
    localparam int ROW_W          = $clog2(SCREEN_HEIGHT);
    localparam int COL_W          = $clog2(SCREEN_WIDTH);
    localparam int FONT_BYTES     = 80;

    localparam logic [12:0] PC_START = 13'h200;

    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_PIXEL = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_PC_RANGE  = 3'd3;
    localparam logic [2:0] ST_ILLEGAL   = 3'd4;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
        logic       writes_flag;
        logic       legal;
    } t_alu_res;

endpackage

// ===== src/c8_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
// Used for main memory, framebuffer rows and the register file; no dependencies.
module c8_ram #(
    parameter int W  = 8,
    parameter int D  = 4096,
    parameter int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== src/c8_alu.sv =====
// Register-to-register ALU for the 8xyN instruction group.
// Depends on c8_pkg for the result struct.
module c8_alu (
    input  logic [7:0]        i_vx,
    input  logic [7:0]        i_vy,
    input  logic [3:0]        i_func,
    output c8_pkg::t_alu_res  o_res
);
    import c8_pkg::*;

    logic [8:0] sum;

    assign sum = {1'b0, i_vx} + {1'b0, i_vy};

    always_comb begin
        o_res = '{res: i_vy, flag: 1'b0, writes_flag: 1'b1, legal: 1'b1};
        case (i_func)
            4'h0: begin
                o_res.writes_flag = 1'b0;
            end
            4'h1: o_res.res = i_vx | i_vy;
            4'h2: o_res.res = i_vx & i_vy;
            4'h3: o_res.res = i_vx ^ i_vy;
            4'h4: begin
                o_res.res  = sum[7:0];
                o_res.flag = sum[8];
            end
            4'h5: begin
                o_res.res  = i_vx - i_vy;
                o_res.flag = (i_vx >= i_vy);
            end
            4'h6: begin
                o_res.res  = {1'b0, i_vy[7:1]};
                o_res.flag = i_vy[0];
            end
            4'h7: begin
                o_res.res  = i_vy - i_vx;
                o_res.flag = (i_vy >= i_vx);
            end
            4'hE: begin
                o_res.res  = {i_vy[6:0], 1'b0};
                o_res.flag = i_vy[7];
            end
            default: begin
                o_res.legal       = 1'b0;
                o_res.writes_flag = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/chip8_instruction_core_unit.sv =====
// CHIP-8 instruction core: a sequencer around main memory, framebuffer and register file RAMs.
// After reset the block sweeps main memory (font load, rest zero), framebuffer and register file while busy.
// One request at a time; the next one is taken in the cycle the one-cycle result strobe shows.
// Depends on c8_pkg, c8_ram and c8_alu.
module chip8_instruction_core_unit #(
    parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_keys_down,
    input  logic [7:0]  i_random_byte,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic        o_pixel,
    output logic [12:0] o_program_counter,
    output logic        o_sound_on
);
    import c8_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_ACT, S_PIX, S_F1, S_F2, S_F3, S_F4, S_EXEC, S_WRF,
        S_CLS, S_D1, S_D2, S_D3, S_BCD, S_S1, S_S2, S_L1, S_L2
    } t_state;

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [1:0]  r_act;
    logic [11:0] r_addr;
    logic [7:0]  r_data, r_rnd;
    logic [15:0] r_keys;
    logic [12:0] r_pc, n_pc;
    logic [15:0] r_i, n_i;
    logic [SPW-1:0] r_sp, n_sp;
    logic [7:0]  r_dt, n_dt, r_st, n_st;
    logic        r_key_seen, n_key_seen;
    logic [3:0]  r_key_held, n_key_held;
    logic [7:0]  r_hi, n_hi, r_lo, n_lo, r_vx, n_vx, r_vy, n_vy, r_spr, n_spr;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_flag, n_flag;
    logic [3:0]  r_bcd [3];
    logic [3:0]  n_bcd [3];
    logic        r_done, n_done;
    logic [2:0]  r_status, n_status;
    logic        r_pixel, n_pixel;
    logic [11:0] r_stack [STACK_DEPTH];
    logic        stk_we;
    logic [SIW-1:0] stk_widx, stk_ridx;

    logic        m_we;
    logic [11:0] m_waddr, m_raddr;
    logic [7:0]  m_wdata, m_rdata;
    logic        f_we;
    logic [ROW_W-1:0] f_waddr, f_raddr;
    logic [SCREEN_WIDTH-1:0] f_wdata, f_rdata;
    logic        rf_we;
    logic [3:0]  rf_waddr, rf_raddr;
    logic [7:0]  rf_wdata, rf_rdata;

    t_alu_res    alu;
    logic [SCREEN_WIDTH-1:0] mask;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] draw_row;
    logic [11:0] i_off;
    logic [12:0] pc_next, pc_skip;
    logic [11:0] nnn;
    logic [3:0]  x;
    logic        key_any;
    logic [3:0]  key_low;
    logic [1:0]  hund;
    logic [6:0]  rem;
    logic [14:0] tens_prod;
    logic [3:0]  tens;

    c8_ram #(.W(8), .D(MEMORY_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    c8_ram #(.W(SCREEN_WIDTH), .D(SCREEN_HEIGHT)) u_fb (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    c8_ram #(.W(8), .D(16)) u_rf (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_raddr(rf_raddr), .o_rdata(rf_rdata)
    );

    c8_alu u_alu (.i_vx(r_vx), .i_vy(r_vy), .i_func(r_lo[3:0]), .o_res(alu));

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_pixel           = r_pixel;
    assign o_program_counter = r_pc;
    assign o_sound_on        = (r_st != 8'd0);

    assign x        = r_hi[3:0];
    assign nnn      = {r_hi[3:0], r_lo};
    assign pc_next  = r_pc + 13'd2;
    assign pc_skip  = r_pc + 13'd4;
    assign i_off    = r_i[11:0] + {7'd0, r_cnt};
    assign draw_row = r_vy[ROW_W-1:0] + r_cnt[ROW_W-1:0];
    assign stk_ridx = SIW'(r_sp - SPW'(1));
    assign stk_widx = SIW'(r_sp);

    // Sprite byte placed on the row with horizontal wrap.
    always_comb begin
        mask = '0;
        col  = '0;
        for (int j = 0; j < 8; j++) begin
            col       = r_vx[COL_W-1:0] + COL_W'(j);
            mask[col] = mask[col] | r_spr[7-j];
        end
    end

    // Lowest held key.
    always_comb begin
        key_any = 1'b0;
        key_low = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) begin
                key_any = 1'b1;
                key_low = 4'(k);
            end
        end
    end

    // Decimal digits of Vx; tens uses a reciprocal multiply valid below 100.
    always_comb begin
        if (r_vx >= 8'd200) begin
            hund = 2'd2;
            rem  = 7'(r_vx - 8'd200);
        end else if (r_vx >= 8'd100) begin
            hund = 2'd1;
            rem  = 7'(r_vx - 8'd100);
        end else begin
            hund = 2'd0;
            rem  = r_vx[6:0];
        end
        tens_prod = {8'd0, rem} * 15'd205;
        tens      = tens_prod[14:11];
    end

    always_comb begin
        n_state = r_state;  n_clr = r_clr;  n_pc = r_pc;  n_i = r_i;  n_sp = r_sp;
        n_dt = r_dt;  n_st = r_st;  n_key_seen = r_key_seen;  n_key_held = r_key_held;
        n_hi = r_hi;  n_lo = r_lo;  n_vx = r_vx;  n_vy = r_vy;  n_spr = r_spr;
        n_cnt = r_cnt;  n_flag = r_flag;  n_bcd = r_bcd;
        n_done = 1'b0;  n_status = r_status;  n_pixel = r_pixel;
        stk_we = 1'b0;
        m_we = 1'b0;  m_waddr = i_off;  m_wdata = 8'd0;  m_raddr = r_pc[11:0];
        f_we = 1'b0;  f_waddr = draw_row;  f_wdata = f_rdata ^ mask;  f_raddr = draw_row;
        rf_we = 1'b0;  rf_waddr = x;  rf_wdata = 8'd0;  rf_raddr = x;

        case (r_state)
            S_INIT: begin
                m_we     = 1'b1;
                m_waddr  = r_clr;
                m_wdata  = (r_clr < ADDR_W'(FONT_BYTES)) ? FONT[r_clr[6:0]] : 8'd0;
                f_we     = 1'b1;
                f_waddr  = r_clr[ROW_W-1:0];
                f_wdata  = '0;
                rf_we    = 1'b1;
                rf_waddr = r_clr[3:0];
                n_clr    = r_clr + ADDR_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_status = ST_OK;
                n_pixel  = 1'b0;
                if (start) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                n_status = ST_OK;
                case (r_act)
                    ACT_TICK: begin
                        if (r_dt != 8'd0) n_dt = r_dt - 8'd1;
                        if (r_st != 8'd0) n_st = r_st - 8'd1;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    ACT_WRITE: begin
                        m_we    = 1'b1;
                        m_waddr = r_addr;
                        m_wdata = r_data;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    ACT_PIXEL: begin
                        f_raddr = r_addr[COL_W+ROW_W-1:COL_W];
                        if (r_addr[11]) begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_PIX;
                        end
                    end
                    default: begin
                        if (r_pc[12]) begin
                            n_status = ST_PC_RANGE;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_F1;
                        end
                    end
                endcase
            end
            S_PIX: begin
                n_pixel = f_rdata[r_addr[COL_W-1:0]];
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_F1: begin
                n_hi    = m_rdata;
                m_raddr = r_pc[11:0] + 12'd1;
                n_state = S_F2;
            end
            S_F2: begin
                n_lo    = m_rdata;
                n_state = S_F3;
            end
            S_F3: begin
                n_vx     = rf_rdata;
                rf_raddr = r_lo[7:4];
                n_state  = S_F4;
            end
            S_F4: begin
                n_vy     = rf_rdata;
                rf_raddr = 4'd0;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                // Default: finish with ok status and pc + 2.
                n_done  = 1'b1;
                n_state = S_IDLE;
                n_pc    = pc_next;
                n_cnt   = 5'd0;
                case (r_hi[7:4])
                    4'h0: begin
                        if (r_hi == 8'h00 && r_lo == 8'hE0) begin
                            n_done  = 1'b0;
                            n_state = S_CLS;
                        end else if (r_hi == 8'h00 && r_lo == 8'hEE) begin
                            if (r_sp == '0) begin
                                n_status = ST_UNDERFLOW;
                                n_pc     = r_pc;
                            end else begin
                                n_sp = r_sp - SPW'(1);
                                n_pc = {1'b0, r_stack[stk_ridx]} + 13'd2;
                            end
                        end else begin
                            n_status = ST_ILLEGAL;
                            n_pc     = r_pc;
                        end
                    end
                    4'h1: n_pc = {1'b0, nnn};
                    4'h2: begin
                        if (r_sp >= SPW'(STACK_DEPTH)) begin
                            n_status = ST_OVERFLOW;
                            n_pc     = r_pc;
                        end else begin
                            stk_we = 1'b1;
                            n_sp   = r_sp + SPW'(1);
                            n_pc   = {1'b0, nnn};
                        end
                    end
                    4'h3: if (r_vx == r_lo) n_pc = pc_skip;
                    4'h4: if (r_vx != r_lo) n_pc = pc_skip;
                    4'h5: if (r_vx == r_vy) n_pc = pc_skip;
                    4'h9: if (r_vx != r_vy) n_pc = pc_skip;
                    4'h6: begin
                        rf_we    = 1'b1;
                        rf_wdata = r_lo;
                    end
                    4'h7: begin
                        rf_we    = 1'b1;
                        rf_wdata = r_vx + r_lo;
                    end
                    4'h8: begin
                        if (!alu.legal) begin
                            n_status = ST_ILLEGAL;
                            n_pc     = r_pc;
                        end else begin
                            rf_we    = 1'b1;
                            rf_wdata = alu.res;
                            n_flag   = alu.flag;
                            if (alu.writes_flag) begin
                                n_done  = 1'b0;
                                n_state = S_WRF;
                            end
                        end
                    end
                    4'hA: n_i = {4'd0, nnn};
                    4'hB: n_pc = {1'b0, nnn + {4'd0, rf_rdata}};
                    4'hC: begin
                        rf_we    = 1'b1;
                        rf_wdata = r_rnd & r_lo;
                    end
                    4'hD: begin
                        n_done = 1'b0;
                        n_flag = 1'b0;
                        n_state = (r_lo[3:0] == 4'd0) ? S_WRF : S_D1;
                    end
                    4'hE: begin
                        if (r_lo == 8'h9E) begin
                            if (r_keys[r_vx[3:0]]) n_pc = pc_skip;
                        end else if (r_lo == 8'hA1) begin
                            if (!r_keys[r_vx[3:0]]) n_pc = pc_skip;
                        end else begin
                            n_status = ST_ILLEGAL;
                            n_pc     = r_pc;
                        end
                    end
                    default: begin
                        case (r_lo)
                            8'h07: begin
                                rf_we    = 1'b1;
                                rf_wdata = r_dt;
                            end
                            8'h0A: begin
                                if (!r_key_seen) begin
                                    n_pc = r_pc;
                                    if (key_any) begin
                                        n_key_seen = 1'b1;
                                        n_key_held = key_low;
                                    end
                                end else if (r_keys[r_key_held]) begin
                                    n_pc = r_pc;
                                end else begin
                                    n_key_seen = 1'b0;
                                    rf_we      = 1'b1;
                                    rf_wdata   = {4'd0, r_key_held};
                                end
                            end
                            8'h15: n_dt = r_vx;
                            8'h18: n_st = r_vx;
                            8'h1E: n_i = r_i + {8'd0, r_vx};
                            8'h29: n_i = {12'd0, r_vx[3:0]} * 16'd5;
                            8'h33: begin
                                n_bcd[0] = {2'd0, hund};
                                n_bcd[1] = tens;
                                n_bcd[2] = 4'(rem - {tens, 3'd0} - {2'd0, tens, 1'b0});
                                n_done   = 1'b0;
                                n_state  = S_BCD;
                            end
                            8'h55: begin
                                n_done  = 1'b0;
                                n_state = S_S1;
                            end
                            8'h65: begin
                                n_done  = 1'b0;
                                n_state = S_L1;
                            end
                            default: begin
                                n_status = ST_ILLEGAL;
                                n_pc     = r_pc;
                            end
                        endcase
                    end
                endcase
            end
            S_WRF: begin
                // The flag write comes after the Vx write so that it wins when x is 15.
                rf_we    = 1'b1;
                rf_waddr = 4'hF;
                rf_wdata = {7'd0, r_flag};
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_CLS: begin
                f_we    = 1'b1;
                f_waddr = r_cnt[ROW_W-1:0];
                f_wdata = '0;
                n_cnt   = r_cnt + 5'd1;
                if (r_cnt == 5'(SCREEN_HEIGHT - 1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_D1: begin
                m_raddr = i_off;
                n_state = S_D2;
            end
            S_D2: begin
                n_spr   = m_rdata;
                n_state = S_D3;
            end
            S_D3: begin
                f_we   = 1'b1;
                n_flag = r_flag | (|(f_rdata & mask));
                n_cnt  = r_cnt + 5'd1;
                if (n_cnt == {1'b0, r_lo[3:0]}) begin
                    n_state = S_WRF;
                end else begin
                    n_state = S_D1;
                end
            end
            S_BCD: begin
                m_we    = 1'b1;
                m_wdata = {4'd0, r_bcd[r_cnt[1:0]]};
                n_cnt   = r_cnt + 5'd1;
                if (r_cnt == 5'd2) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_S1: begin
                rf_raddr = r_cnt[3:0];
                n_state  = S_S2;
            end
            S_S2: begin
                m_we    = 1'b1;
                m_wdata = rf_rdata;
                n_cnt   = r_cnt + 5'd1;
                if (r_cnt[3:0] == x) begin
                    n_i     = r_i + {12'd0, x} + 16'd1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_S1;
                end
            end
            S_L1: begin
                m_raddr = i_off;
                n_state = S_L2;
            end
            S_L2: begin
                rf_we    = 1'b1;
                rf_waddr = r_cnt[3:0];
                rf_wdata = m_rdata;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt[3:0] == x) begin
                    n_i     = r_i + {12'd0, x} + 16'd1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_L1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_clr      <= '0;
            r_pc       <= PC_START;
            r_i        <= 16'd0;
            r_sp       <= '0;
            r_dt       <= 8'd0;
            r_st       <= 8'd0;
            r_key_seen <= 1'b0;
            r_key_held <= 4'd0;
            r_done     <= 1'b0;
            r_status   <= ST_OK;
            r_pixel    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_pc       <= n_pc;
            r_i        <= n_i;
            r_sp       <= n_sp;
            r_dt       <= n_dt;
            r_st       <= n_st;
            r_key_seen <= n_key_seen;
            r_key_held <= n_key_held;
            r_done     <= n_done;
            r_status   <= n_status;
            r_pixel    <= n_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_act  <= i_action;
            r_addr <= i_address;
            r_data <= i_data;
            r_keys <= i_keys_down;
            r_rnd  <= i_random_byte;
        end
        if (stk_we) begin
            r_stack[stk_widx] <= r_pc[11:0];
        end
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_vx  <= n_vx;
        r_vy  <= n_vy;
        r_spr <= n_spr;
        r_cnt <= n_cnt;
        r_flag <= n_flag;
        r_bcd <= n_bcd;
    end

endmodule

// ===== tb/chip8_instruction_core_unit_checker.sv =====
// Checker for the CHIP-8 instruction core: watches requests and result strobes,
// keeps its own copy of the processor state and compares every result field.
// Depends on c8_pkg.
`timescale 1ns / 100ps

module chip8_instruction_core_unit_checker #(
    parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_action,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_keys_down,
    input  logic [7:0]  i_random_byte,
    input  logic        o_done,
    input  logic [2:0]  o_status,
    input  logic        o_pixel,
    input  logic [12:0] o_program_counter,
    input  logic        o_sound_on,
    output int          o_errors,
    output int          o_pending,
    output int          o_compared
);
    import c8_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic        pixel;
        logic [12:0] pc;
        logic        sound;
    } t_step_result;

    logic [7:0]  v_reg [16];
    logic [15:0] index_reg;
    logic [12:0] pc;
    logic [11:0] ret_stack [STACK_DEPTH];
    int          stack_lvl;
    logic [7:0]  delay_tmr;
    logic [7:0]  sound_tmr;
    logic [7:0]  mem [MEMORY_BYTES];
    logic        frame [SCREEN_WIDTH * SCREEN_HEIGHT];
    logic        key_seen;
    logic [3:0]  key_held;

    t_step_result expected_results[$];

    assign o_pending = expected_results.size();

    task automatic reset_state();
        foreach (v_reg[k]) v_reg[k] = '0;
        foreach (ret_stack[k]) ret_stack[k] = '0;
        foreach (mem[k]) mem[k] = (k < FONT_BYTES) ? FONT[k] : 8'h00;
        foreach (frame[k]) frame[k] = 1'b0;
        index_reg = '0;
        pc        = PC_START;
        stack_lvl = 0;
        delay_tmr = '0;
        sound_tmr = '0;
        key_seen  = 1'b0;
        key_held  = '0;
    endtask

    // Executes the instruction at pc; on any error status the state is left untouched.
    task automatic run_instruction(input logic [15:0] keys, input logic [7:0] rnd,
                                   output logic [2:0] stat);
        logic [7:0]  hi, lo, vx, vy, line, col8, row8;
        logic [3:0]  x, y, n;
        logic [11:0] nnn;
        logic [13:0] nxt;
        logic [8:0]  sum;
        logic        hit, found;
        stat = ST_OK;
        if (pc >= 13'h1000) begin
            stat = ST_PC_RANGE;
            return;
        end
        hi  = mem[pc[11:0]];
        lo  = mem[pc[11:0] + 12'd1];
        x   = hi[3:0];
        y   = lo[7:4];
        n   = lo[3:0];
        nnn = {hi[3:0], lo};
        vx  = v_reg[x];
        vy  = v_reg[y];
        nxt = {1'b0, pc} + 14'd2;
        case (hi[7:4])
            4'h0: begin
                if (hi == 8'h00 && lo == 8'hE0) begin
                    foreach (frame[k]) frame[k] = 1'b0;
                end else if (hi == 8'h00 && lo == 8'hEE) begin
                    if (stack_lvl == 0) begin
                        stat = ST_UNDERFLOW;
                        return;
                    end
                    stack_lvl--;
                    nxt = {2'b00, ret_stack[stack_lvl]} + 14'd2;
                end else begin
                    stat = ST_ILLEGAL;
                    return;
                end
            end
            4'h1: nxt = {2'b00, nnn};
            4'h2: begin
                if (stack_lvl >= STACK_DEPTH) begin
                    stat = ST_OVERFLOW;
                    return;
                end
                ret_stack[stack_lvl] = pc[11:0];
                stack_lvl++;
                nxt = {2'b00, nnn};
            end
            4'h3: if (vx == lo) nxt += 14'd2;
            4'h4: if (vx != lo) nxt += 14'd2;
            4'h5: if (vx == vy) nxt += 14'd2;
            4'h6: v_reg[x] = lo;
            4'h7: v_reg[x] = vx + lo;
            4'h8: begin
                case (n)
                    4'h0: v_reg[x] = vy;
                    4'h1: begin v_reg[x] = vx | vy; v_reg[15] = 8'd0; end
                    4'h2: begin v_reg[x] = vx & vy; v_reg[15] = 8'd0; end
                    4'h3: begin v_reg[x] = vx ^ vy; v_reg[15] = 8'd0; end
                    4'h4: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        v_reg[x] = sum[7:0];
                        v_reg[15] = {7'd0, sum[8]};
                    end
                    4'h5: begin v_reg[x] = vx - vy; v_reg[15] = {7'd0, vx >= vy}; end
                    4'h6: begin v_reg[x] = vy >> 1; v_reg[15] = {7'd0, vy[0]}; end
                    4'h7: begin v_reg[x] = vy - vx; v_reg[15] = {7'd0, vy >= vx}; end
                    4'hE: begin v_reg[x] = vy << 1; v_reg[15] = {7'd0, vy[7]}; end
                    default: begin
                        stat = ST_ILLEGAL;
                        return;
                    end
                endcase
            end
            4'h9: if (vx != vy) nxt += 14'd2;
            4'hA: index_reg = {4'd0, nnn};
            4'hB: nxt = {2'b00, nnn + {4'd0, v_reg[0]}};
            4'hC: v_reg[x] = rnd & lo;
            4'hD: begin
                hit = 1'b0;
                for (int i = 0; i < n; i++) begin
                    line = mem[index_reg[11:0] + 12'(i)];
                    row8 = vy + 8'(i);
                    for (int j = 0; j < 8; j++) begin
                        col8 = vx + 8'(j);
                        if (line[7-j]) begin
                            if (frame[{row8[4:0], col8[5:0]}]) hit = 1'b1;
                            frame[{row8[4:0], col8[5:0]}] ^= 1'b1;
                        end
                    end
                end
                v_reg[15] = {7'd0, hit};
            end
            4'hE: begin
                if (lo == 8'h9E) begin
                    if (keys[vx[3:0]]) nxt += 14'd2;
                end else if (lo == 8'hA1) begin
                    if (!keys[vx[3:0]]) nxt += 14'd2;
                end else begin
                    stat = ST_ILLEGAL;
                    return;
                end
            end
            default: begin
                case (lo)
                    8'h07: v_reg[x] = delay_tmr;
                    8'h0A: begin
                        if (!key_seen) begin
                            found = 1'b0;
                            for (int k = 0; k < 16; k++) begin
                                if (keys[k] && !found) begin
                                    found    = 1'b1;
                                    key_seen = 1'b1;
                                    key_held = 4'(k);
                                end
                            end
                            nxt = {1'b0, pc};
                        end else if (keys[key_held]) begin
                            nxt = {1'b0, pc};
                        end else begin
                            key_seen = 1'b0;
                            v_reg[x] = {4'd0, key_held};
                        end
                    end
                    8'h15: delay_tmr = vx;
                    8'h18: sound_tmr = vx;
                    8'h1E: index_reg = index_reg + {8'd0, vx};
                    8'h29: index_reg = 16'(5 * vx[3:0]);
                    8'h33: begin
                        mem[index_reg[11:0]]         = vx / 100;
                        mem[index_reg[11:0] + 12'd1] = (vx / 10) % 10;
                        mem[index_reg[11:0] + 12'd2] = vx % 10;
                    end
                    8'h55: begin
                        for (int k = 0; k <= x; k++)
                            mem[index_reg[11:0] + 12'(k)] = v_reg[k];
                        index_reg = index_reg + 16'(x) + 16'd1;
                    end
                    8'h65: begin
                        for (int k = 0; k <= x; k++)
                            v_reg[k] = mem[index_reg[11:0] + 12'(k)];
                        index_reg = index_reg + 16'(x) + 16'd1;
                    end
                    default: begin
                        stat = ST_ILLEGAL;
                        return;
                    end
                endcase
            end
        endcase
        pc = nxt[12:0];
    endtask

    task automatic predict_step(output t_step_result res);
        logic [2:0] stat;
        stat = ST_OK;
        res.pixel = 1'b0;
        case (i_action)
            ACT_EXEC: run_instruction(i_keys_down, i_random_byte, stat);
            ACT_TICK: begin
                if (delay_tmr != 0) delay_tmr--;
                if (sound_tmr != 0) sound_tmr--;
            end
            ACT_WRITE: mem[i_address] = i_data;
            default: if (i_address < SCREEN_WIDTH * SCREEN_HEIGHT) res.pixel = frame[i_address[10:0]];
        endcase
        res.status = stat;
        res.pc     = pc;
        res.sound  = (sound_tmr != 0);
    endtask

    always @(posedge i_clk) begin
        t_step_result exp_res;
        t_step_result got;
        if (!i_rst_n) begin
            reset_state();
            expected_results.delete();
            o_errors   <= 0;
            o_compared <= 0;
        end else begin
            // Results are checked before the new request is predicted.
            if (o_done) begin
                got = '{o_status, o_pixel, o_program_counter, o_sound_on};
                if (expected_results.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: result with no request pending: %p", $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_res = expected_results.pop_front();
                    o_compared <= o_compared + 1;
                    if (got !== exp_res) begin
                        if (o_errors < 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, exp_res, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (start && !busy) begin
                predict_step(exp_res);
                expected_results.push_back(exp_res);
            end
        end
    end

endmodule

// ===== tb/chip8_instruction_core_unit_tb.sv =====
// Top of the CHIP-8 instruction core testbench: clock, reset and request stimulus.
// Depends on c8_pkg, the core and chip8_instruction_core_unit_checker.
`timescale 1ns / 100ps

module chip8_instruction_core_unit_tb;
    import c8_pkg::*;

    localparam int RANDOM_REQUESTS = 1600;
    localparam int CYCLE_LIMIT     = 2_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_action = ACT_TICK;
    logic [11:0] i_address = '0;
    logic [7:0]  i_data = '0;
    logic [15:0] i_keys_down = '0;
    logic [7:0]  i_random_byte = '0;
    logic        o_done;
    logic [2:0]  o_status;
    logic        o_pixel;
    logic [12:0] o_program_counter;
    logic        o_sound_on;
    int          errors, pending, compared;
    int          cycles = 0;
    int          requests = 0;
    int          act_count [4] = '{0, 0, 0, 0};
    logic [12:0] cur_pc = PC_START;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    chip8_instruction_core_unit dut (.*);

    chip8_instruction_core_unit_checker checker_i (.*, .o_errors(errors),
        .o_pending(pending), .o_compared(compared));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [15:0] random_keys();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'h0001 << $urandom_range(0, 15);
            default: return 16'($urandom());
        endcase
    endfunction

    // One request: optional idle gap, wait for acceptance, then wait for its result.
    task automatic issue(input logic [1:0] act, input logic [11:0] addr, input logic [7:0] dat);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge i_clk);
        start         <= 1'b1;
        i_action      <= act;
        i_address     <= addr;
        i_data        <= dat;
        i_keys_down   <= random_keys();
        i_random_byte <= 8'($urandom());
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
        @(posedge i_clk);
        while (!o_done) @(posedge i_clk);
        cur_pc = o_program_counter;
        requests++;
        act_count[act]++;
    endtask

    task automatic load_and_run(input logic [15:0] opcode);
        issue(ACT_WRITE, cur_pc[11:0], opcode[15:8]);
        issue(ACT_WRITE, cur_pc[11:0] + 12'd1, opcode[7:0]);
        issue(ACT_EXEC, '0, '0);
    endtask

    function automatic logic [15:0] random_opcode();
        logic [3:0]  x, y;
        logic [7:0]  kk;
        logic [11:0] target;
        logic [7:0]  f_ops [10] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29,
                                   8'h33, 8'h55, 8'h65, 8'h00};
        int          sel;
        x      = 4'($urandom());
        y      = 4'($urandom());
        kk     = 8'($urandom());
        target = 12'($urandom_range(0, 12'hFF7));
        sel    = $urandom_range(0, 99);
        if (sel < 2)  return 16'h00E0;
        if (sel < 7)  return 16'h00EE;
        if (sel < 8)  return {8'h0, kk};
        if (sel < 12) return {4'h1, target};
        if (sel < 17) return {4'h2, target};
        if (sel < 29) return {4'($urandom_range(3, 5)) | ($urandom_range(0, 3) == 0 ? 4'h8 : 4'h0),
                              x, (kk[0] ? y : 4'($urandom())), kk[7:4]};
        if (sel < 39) return {4'h6, x, kk};
        if (sel < 45) return {4'h7, x, kk};
        if (sel < 60) return {4'h8, x, y, 4'($urandom())};
        if (sel < 66) return {4'hA, 12'($urandom())};
        if (sel < 69) return {4'hB, 12'($urandom())};
        if (sel < 73) return {4'hC, x, kk};
        if (sel < 81) return {4'hD, x, y, 4'($urandom())};
        if (sel < 85) return {4'hE, x, (sel == 84) ? kk : (kk[0] ? 8'h9E : 8'hA1)};
        return {4'hF, x, ($urandom_range(0, 19) == 0) ? kk : f_ops[$urandom_range(0, 8)]};
    endfunction

    initial begin
        int sel;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty memory is illegal, return with empty stack, pixel edges,
        // an add with no carry, sound timer and draw with and without collision.
        issue(ACT_EXEC, '0, '0);
        issue(ACT_WRITE, cur_pc[11:0] + 12'd1, 8'hEE);
        issue(ACT_EXEC, '0, '0);
        issue(ACT_PIXEL, 12'd0, '0);
        issue(ACT_PIXEL, 12'd2047, '0);
        issue(ACT_PIXEL, 12'hFFF, 8'hFF);
        load_and_run(16'h60FF);
        load_and_run(16'h8004 | 16'h0010);
        load_and_run(16'h62FF);
        load_and_run(16'hF218);
        issue(ACT_TICK, '0, '0);
        load_and_run(16'hD12F);
        load_and_run(16'hD12F);

        while (requests < RANDOM_REQUESTS + 30) begin
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                // Steer away from the top of memory so the pc stays in range.
                if (cur_pc >= 13'hFF8)
                    load_and_run({4'h1, 12'($urandom_range(12'h200, 12'hF00))});
                else begin
                    load_and_run(random_opcode());
                    repeat ($urandom_range(0, 2)) issue(ACT_EXEC, '0, '0);
                end
            end else if (sel < 75) begin
                issue(ACT_TICK, 12'($urandom()), 8'($urandom()));
            end else if (sel < 85) begin
                issue(ACT_PIXEL, $urandom_range(0, 1) ? 12'($urandom_range(0, 2047))
                                                      : 12'($urandom()), 8'($urandom()));
            end else if (sel < 93) begin
                issue(ACT_WRITE, 12'($urandom()), 8'($urandom()));
            end else if (cur_pc < 13'hFF0) begin
                issue(ACT_EXEC, 12'($urandom()), 8'($urandom()));
            end
        end

        // Pc run-off at the very end, since nothing can bring it back.
        load_and_run(16'h1FFE);
        load_and_run(16'h5000);
        issue(ACT_EXEC, '0, '0);

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Ran %0d requests: %0d executes, %0d ticks, %0d writes, %0d pixel reads.",
                 requests, act_count[ACT_EXEC], act_count[ACT_TICK],
                 act_count[ACT_WRITE], act_count[ACT_PIXEL]);
        $display("Compared %0d results, %0d failures.", compared, errors);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
